### rtl/modbus_rtu_register_poller_defines.svh
`ifndef MODBUS_RTU_REGISTER_POLLER_DEFINES_SVH
`define MODBUS_RTU_REGISTER_POLLER_DEFINES_SVH

// property checked on every clock edge outside of reset
`define MRP_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("modbus poller check failed");

// property checked on every clock edge, reset included
`define MRP_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("modbus poller check failed during reset");

`endif

### rtl/mrp_pkg.sv
`timescale 1ns / 1ps

package mrp_pkg;

	// protocol constants
	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0]  REPLY_BYTE_COUNT  = 8'h02;
	localparam logic [7:0]  QTY_HIGH          = 8'h00;
	localparam logic [7:0]  QTY_LOW           = 8'h01;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;

	// byte positions in request and reply
	localparam logic [2:0] TX_CRC_LO_IDX  = 3'd6;
	localparam logic [2:0] TX_LAST_IDX    = 3'd7;
	localparam logic [2:0] RX_LAST_POS    = 3'd6;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REG_ADDR   = 8'd1;
	localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;
	localparam logic [15:0] REG_ADDR_RESET   = 16'h0101;

	// input mode and result kind codes
	localparam logic MODE_POLL    = 1'b0;
	localparam logic MODE_RX      = 1'b1;
	localparam logic KIND_TX      = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SLAVE = 3'd1,
		ST_BAD_FUNC  = 3'd2,
		ST_BAD_COUNT = 3'd3,
		ST_BAD_CRC   = 3'd4
	} status_t;

	// classified command between front and back
	typedef struct packed {
		logic       poll;
		logic [7:0] data;
		logic [2:0] pos;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic       last;
		logic [15:0] reading;
		status_t    status;
	} res_t;

	// fold one byte into a modbus crc
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### rtl/modbus_rtu_register_poller.sv
`timescale 1ns / 1ps
// Modbus RTU master that reads one holding register per poll.
// Input queue side: push/full with mode and rx_byte. mode 0 issues a poll,
// mode 1 hands in one received reply byte. Reply bytes with no poll
// outstanding are accepted and dropped.
// Result queue side: empty/pop with kind, tx_byte, last, reading, status.
// A poll yields eight transmit bytes (last on the eighth); the seventh
// reply byte yields one verdict with the reading or the first error.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 slave id,
// 1 register address) and cfg_data; cfg_ready is always high.
// Timing: a front stage classifies each item into a CMD_DEPTH command
// queue; the back end turns a poll into eight bytes, one per cycle while
// the result queue has room, and takes no other command until the last
// byte is out. The first result passes the command queue and result queue
// registers. The back end writes at most a single result per cycle.
// Reset clears all control state and loads the register defaults.
// When pop stays low the result queue fills, the back end holds, and then
// the command queue fills and full rises; nothing is lost.
module modbus_rtu_register_poller
	import mrp_pkg::*;
#(
	parameter int CMD_DEPTH = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  mode,
	input  logic [7:0]            rx_byte,
	output logic                  empty,
	input  logic                  pop,
	output logic                  kind,
	output logic [7:0]            tx_byte,
	output logic                  last,
	output logic [15:0]           reading,
	output logic [2:0]            status,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	logic [7:0]  slave_addr_q;
	logic [15:0] reg_addr_q;

	logic cmd_full;
	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_empty;
	logic cmd_pop;
	cmd_t cmd_out;
	logic res_full;
	logic res_push;
	res_t res_in;
	res_t res_out;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RESET;
			reg_addr_q   <= REG_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SLAVE_ADDR: slave_addr_q <= cfg_data[7:0];
				REG_REG_ADDR:   reg_addr_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	// front: accept and classify
	mrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.mode     (mode),
		.rx_byte  (rx_byte),
		.full     (full),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// command queue between front and back
	mrp_fifo #(.T(cmd_t), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// back: request generation and reply checking
	mrp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.slave_addr (slave_addr_q),
		.reg_addr   (reg_addr_q),
		.cmd_valid  (!cmd_empty),
		.cmd        (cmd_out),
		.cmd_pop    (cmd_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_in)
	);

	// result queue
	mrp_fifo #(.T(res_t), .DEPTH(RES_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign kind    = res_out.kind;
	assign tx_byte = res_out.tx_byte;
	assign last    = res_out.last;
	assign reading = res_out.reading;
	assign status  = res_out.status;

endmodule

### rtl/mrp_fifo.sv
`timescale 1ns / 1ps

module mrp_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### rtl/mrp_front.sv
`timescale 1ns / 1ps

module mrp_front
	import mrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       mode,
	input  logic [7:0] rx_byte,
	output logic       full,
	input  logic       cmd_full,
	output logic       cmd_push,
	output cmd_t       cmd
);
	logic       awaiting_q;
	logic [2:0] pos_q;
	logic       accept;
	logic       is_poll;

	assign full    = cmd_full;
	assign accept  = push && !cmd_full;
	assign is_poll = (mode == MODE_POLL);

	// polls always go on, reply bytes only while a poll is outstanding
	assign cmd_push  = accept && (is_poll || awaiting_q);
	assign cmd.poll  = is_poll;
	assign cmd.data  = rx_byte;
	assign cmd.pos   = pos_q;

	// reply tracking: which byte of the reply comes next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			pos_q      <= '0;
		end else if (accept) begin
			if (is_poll) begin
				awaiting_q <= 1'b1;
				pos_q      <= '0;
			end else if (awaiting_q) begin
				if (pos_q == RX_LAST_POS) begin
					awaiting_q <= 1'b0;
					pos_q      <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/mrp_back.sv
`timescale 1ns / 1ps

module mrp_back
	import mrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  slave_addr,
	input  logic [15:0] reg_addr,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	input  logic        res_full,
	output logic        res_push,
	output res_t        res
);
	// request sequencer
	logic        tx_active_q;
	logic [2:0]  tx_idx_q;
	logic [15:0] tx_crc_q;
	// reply state
	logic [15:0] rx_crc_q;
	status_t     first_err_q;
	logic [7:0]  val_hi_q;
	logic [7:0]  val_lo_q;
	logic [7:0]  crc_lo_q;

	logic        start_poll;
	logic        doing_tx;
	logic        emit_tx;
	logic [2:0]  cur_idx;
	logic [15:0] crc_in;
	logic [7:0]  tx_b;
	logic        rx_cmd;
	logic        rx_final;
	logic        rx_take;
	status_t     rx_err;
	status_t     verdict;

	assign start_poll = !tx_active_q && cmd_valid && cmd.poll;
	assign doing_tx   = tx_active_q || start_poll;
	assign emit_tx    = doing_tx && !res_full;
	assign cur_idx    = tx_active_q ? tx_idx_q : 3'd0;
	assign crc_in     = tx_active_q ? tx_crc_q : CRC_INIT;

	assign rx_cmd   = !tx_active_q && cmd_valid && !cmd.poll;
	assign rx_final = (cmd.pos == RX_LAST_POS);
	assign rx_take  = rx_cmd && (!rx_final || !res_full);

	assign cmd_pop  = (start_poll && !res_full) || rx_take;

	// request byte for the current position
	always_comb begin
		case (cur_idx)
			3'd0:    tx_b = slave_addr;
			3'd1:    tx_b = FUNC_READ_HOLDING;
			3'd2:    tx_b = reg_addr[15:8];
			3'd3:    tx_b = reg_addr[7:0];
			3'd4:    tx_b = QTY_HIGH;
			3'd5:    tx_b = QTY_LOW;
			3'd6:    tx_b = crc_in[7:0];
			default: tx_b = crc_in[15:8];
		endcase
	end

	// error check of the reply byte at its position
	always_comb begin
		rx_err = ST_OK;
		case (cmd.pos)
			3'd0:    if (cmd.data != slave_addr) rx_err = ST_BAD_SLAVE;
			3'd1:    if (cmd.data != FUNC_READ_HOLDING) rx_err = ST_BAD_FUNC;
			3'd2:    if (cmd.data != REPLY_BYTE_COUNT) rx_err = ST_BAD_COUNT;
			default: rx_err = ST_OK;
		endcase
	end

	// final verdict keeps the first error
	always_comb begin
		verdict = first_err_q;
		if (first_err_q == ST_OK && {cmd.data, crc_lo_q} != rx_crc_q) begin
			verdict = ST_BAD_CRC;
		end
	end

	// result item
	always_comb begin
		res_push = emit_tx || (rx_take && rx_final);
		res      = '0;
		if (doing_tx) begin
			res.kind    = KIND_TX;
			res.tx_byte = tx_b;
			res.last    = (cur_idx == TX_LAST_IDX);
			res.status  = ST_OK;
		end else begin
			res.kind    = KIND_VERDICT;
			res.last    = 1'b1;
			res.status  = verdict;
			res.reading = (verdict == ST_OK) ? {val_hi_q, val_lo_q} : 16'h0000;
		end
	end

	// request sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_active_q <= 1'b0;
			tx_idx_q    <= '0;
			tx_crc_q    <= CRC_INIT;
		end else if (emit_tx) begin
			tx_active_q <= (cur_idx != TX_LAST_IDX);
			tx_idx_q    <= cur_idx + 1'b1;
			if (cur_idx < TX_CRC_LO_IDX) begin
				tx_crc_q <= crc_fold(crc_in, tx_b);
			end
		end
	end

	// reply state, cleared when a poll starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_crc_q    <= CRC_INIT;
			first_err_q <= ST_OK;
			val_hi_q    <= '0;
			val_lo_q    <= '0;
			crc_lo_q    <= '0;
		end else if (emit_tx && start_poll) begin
			rx_crc_q    <= CRC_INIT;
			first_err_q <= ST_OK;
			val_hi_q    <= '0;
			val_lo_q    <= '0;
			crc_lo_q    <= '0;
		end else if (rx_take) begin
			if (first_err_q == ST_OK) begin
				first_err_q <= rx_err;
			end
			if (cmd.pos < 3'd5) begin
				rx_crc_q <= crc_fold(rx_crc_q, cmd.data);
			end
			case (cmd.pos)
				3'd3:    val_hi_q <= cmd.data;
				3'd4:    val_lo_q <= cmd.data;
				3'd5:    crc_lo_q <= cmd.data;
				default: ;
			endcase
		end
	end

endmodule

### rtl/mrp_checker.sv
`timescale 1ns / 1ps
`include "modbus_rtu_register_poller_defines.svh"

module mrp_checker
	import mrp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  empty,
	input logic                  pop,
	input logic                  kind,
	input logic                  last,
	input logic [15:0]           reading,
	input logic [2:0]            status
);
	// a verdict always closes its transaction
	`MRP_ASSERT(a_verdict_last, (!empty && kind == KIND_VERDICT) |-> last)

	// transmit bytes carry no reading and no status
	`MRP_ASSERT(a_tx_clean, (!empty && kind == KIND_TX) |-> (reading == 16'h0000 && status == ST_OK))

	// request bytes come out as one unbroken run
	`MRP_ASSERT(a_tx_run, (pop && !empty && kind == KIND_TX && !last) |=> (empty || kind == KIND_TX))

	// a waiting result stays until popped
	`MRP_ASSERT(a_res_hold, (!empty && !pop) |=> !empty)

	// nothing waits right after reset
	`MRP_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> empty)

endmodule

bind modbus_rtu_register_poller mrp_checker u_mrp_checker (.*);
